// ===== src/u8d_pkg.sv =====
package u8d_pkg;

    // Width of the saturating character and byte counters.
    localparam int COUNT_WIDTH = 16;

    localparam int CP_WIDTH    = 31;
    localparam int LEN_WIDTH   = 3;
    localparam int FIELD_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [CP_WIDTH-1:0]    t_code_point;
    typedef logic [LEN_WIDTH-1:0]   t_len;
    typedef logic [FIELD_WIDTH-1:0] t_field;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Lead byte class boundaries.
    localparam logic [7:0] ASCII_TOP  = 8'h7f;
    localparam logic [7:0] LEAD2_LO   = 8'hc0;
    localparam logic [7:0] LEAD2_HI   = 8'hdf;
    localparam logic [7:0] LEAD3_LO   = 8'he0;
    localparam logic [7:0] LEAD3_HI   = 8'hef;
    localparam logic [7:0] LEAD4_LO   = 8'hf0;
    localparam logic [7:0] LEAD4_HI   = 8'hf7;
    localparam logic [7:0] LEAD5_LO   = 8'hf8;
    localparam logic [7:0] LEAD5_HI   = 8'hfb;
    localparam logic [7:0] LEAD6_LO   = 8'hfc;
    localparam logic [7:0] LEAD6_HI   = 8'hfd;

    localparam t_len LEN_ONE = 3'd1;
    localparam t_len LEN_MAX = 3'd6;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : t_count'(v + 1'b1);
    endfunction

endpackage

// ===== src/u8d_if.sv =====
interface u8d_in_if
    import u8d_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source(output valid, output data_byte, output restart, input ready);
    modport sink(input valid, input data_byte, input restart, output ready);
endinterface

interface u8d_out_if
    import u8d_pkg::*;
;
    logic        valid;
    logic        ready;
    t_code_point code_point;
    t_len        seq_length;
    t_field      char_index;
    t_field      byte_offset;

    modport source(
        output valid, output code_point, output seq_length,
        output char_index, output byte_offset, input ready
    );
    modport sink(
        input valid, input code_point, input seq_length,
        input char_index, input byte_offset, output ready
    );
endinterface

// ===== src/utf8_stream_decoder.sv =====
// A byte that is accepted is held in the input register and then decoded into the result
// register, from which its result is offered; bytes that only extend a sequence give no
// result. Throughput: one byte per cycle, set by the single decode step between the
// registers, while the result register is free or the byte gives no result.
// Reset (i_rst_n low, synchronous) clears the decode state, both counters and both
// valid flags; the block is ready to take a byte once reset is released.
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_restart;

    // Decoder state.
    logic [2:0]  r_rem;
    t_code_point r_part;
    t_len        r_len;
    t_count      r_chars;
    t_count      r_bytes;
    t_count      r_start;

    // Result register.
    logic        r_out_valid;
    t_code_point r_out_cp;
    t_len        r_out_len;
    t_field      r_out_index;
    t_field      r_out_offset;

    logic [2:0]  n_rem;
    t_code_point n_part;
    t_len        n_len;
    t_count      n_chars;
    t_count      n_bytes;
    t_count      n_start;

    logic [2:0]  eff_rem;
    t_code_point eff_part;
    t_len        eff_len;
    t_count      eff_chars;
    t_count      eff_bytes;
    t_count      eff_start;

    t_len        lead_len;
    t_code_point lead_pay;
    t_code_point shifted;
    logic        emit;
    t_code_point emit_cp;
    t_len        emit_len;

    logic        out_free;
    logic        advance;

    always_comb begin
        lead_len = LEN_ONE;
        lead_pay = t_code_point'(r_byte);
        case (r_byte) inside
            [8'h00:ASCII_TOP]: begin
                lead_len = LEN_ONE;
                lead_pay = t_code_point'(r_byte);
            end
            [LEAD2_LO:LEAD2_HI]: begin
                lead_len = 3'd2;
                lead_pay = t_code_point'(r_byte[4:0]);
            end
            [LEAD3_LO:LEAD3_HI]: begin
                lead_len = 3'd3;
                lead_pay = t_code_point'(r_byte[3:0]);
            end
            [LEAD4_LO:LEAD4_HI]: begin
                lead_len = 3'd4;
                lead_pay = t_code_point'(r_byte[2:0]);
            end
            [LEAD5_LO:LEAD5_HI]: begin
                lead_len = 3'd5;
                lead_pay = t_code_point'(r_byte[1:0]);
            end
            [LEAD6_LO:LEAD6_HI]: begin
                lead_len = LEN_MAX;
                lead_pay = t_code_point'(r_byte[0]);
            end
            default: begin
                // Stray continuation byte or FE/FF stands alone.
                lead_len = LEN_ONE;
                lead_pay = t_code_point'(r_byte);
            end
        endcase
    end

    always_comb begin
        // A restart wipes the state before this byte is looked at.
        eff_rem   = r_restart ? 3'd0 : r_rem;
        eff_part  = r_restart ? '0 : r_part;
        eff_len   = r_restart ? '0 : r_len;
        eff_chars = r_restart ? '0 : r_chars;
        eff_bytes = r_restart ? '0 : r_bytes;
        eff_start = r_restart ? '0 : r_start;

        shifted  = {eff_part[CP_WIDTH-7:0], r_byte[5:0]};
        n_start  = eff_start;
        n_len    = eff_len;
        n_rem    = eff_rem;
        n_part   = eff_part;
        emit     = 1'b0;
        emit_cp  = lead_pay;
        emit_len = LEN_ONE;

        if (eff_rem == 3'd0) begin
            n_start = eff_bytes;
            n_len   = lead_len;
            if (lead_len == LEN_ONE) begin
                n_part = '0;
                emit   = 1'b1;
            end else begin
                n_part = lead_pay;
                n_rem  = lead_len - 3'd1;
            end
        end else begin
            n_rem  = eff_rem - 3'd1;
            n_part = shifted;
            if (eff_rem == 3'd1) begin
                n_part   = '0;
                emit     = 1'b1;
                emit_cp  = shifted;
                emit_len = eff_len;
            end
        end

        n_chars = emit ? sat_inc(eff_chars) : eff_chars;
        n_bytes = sat_inc(eff_bytes);
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && (out_free || !emit);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_byte    <= i_in.data_byte;
            r_restart <= i_in.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_part  <= '0;
            r_len   <= '0;
            r_chars <= '0;
            r_bytes <= '0;
            r_start <= '0;
        end else if (advance) begin
            r_rem   <= n_rem;
            r_part  <= n_part;
            r_len   <= n_len;
            r_chars <= n_chars;
            r_bytes <= n_bytes;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out_cp     <= emit_cp;
            r_out_len    <= emit_len;
            r_out_index  <= t_field'(eff_chars);
            r_out_offset <= t_field'(n_start);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.code_point  = r_out_cp;
    assign o_out.seq_length  = r_out_len;
    assign o_out.char_index  = r_out_index;
    assign o_out.byte_offset = r_out_offset;

`ifndef SYNTH
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_len != 3'd0 && r_out_len <= LEN_MAX))
        else $error("result length out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd5 && (r_rem == 3'd0 || r_rem < r_len))
        else $error("remaining count inconsistent with sequence length");

    a_single_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_len == LEN_ONE) |-> (r_out_cp[CP_WIDTH-1:8] == '0))
        else $error("single byte result wider than a byte");

    a_start_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_bytes)
        else $error("sequence start beyond bytes consumed");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_index)))
        else $error("pending result lost");
`endif

endmodule
